// ===== design/adsr_pkg.sv =====
package adsr_pkg;

    typedef enum logic [4:0] {
        ST_ATTACK  = 5'b00001,
        ST_DECAY   = 5'b00010,
        ST_SUSTAIN = 5'b00100,
        ST_RELEASE = 5'b01000,
        ST_OFF     = 5'b10000
    } stage_t;

    localparam logic [2:0] CODE_ATTACK  = 3'd0;
    localparam logic [2:0] CODE_DECAY   = 3'd1;
    localparam logic [2:0] CODE_SUSTAIN = 3'd2;
    localparam logic [2:0] CODE_RELEASE = 3'd3;
    localparam logic [2:0] CODE_OFF     = 3'd4;

    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
    localparam logic [1:0] ACT_NOTE_OFF = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEGATO_ON     = 3'd4;

    localparam int RST_ATTACK_STEP   = 38043;
    localparam int RST_DECAY_STEP    = 381;
    localparam int RST_SUSTAIN_LEVEL = 11744051;
    localparam int RST_RELEASE_COEF  = 1902;

    function automatic logic [2:0] stage_code(input stage_t st);
        logic [2:0] code;
        unique case (st)
            ST_ATTACK:  code = CODE_ATTACK;
            ST_DECAY:   code = CODE_DECAY;
            ST_SUSTAIN: code = CODE_SUSTAIN;
            ST_RELEASE: code = CODE_RELEASE;
            default:    code = CODE_OFF;
        endcase
        return code;
    endfunction

endpackage

// ===== design/adsr_cfg_regs.sv =====
module adsr_cfg_regs #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [FRAC_BITS:0]                  wr_data,
    output logic [FRAC_BITS:0]                  attack_step,
    output logic [FRAC_BITS:0]                  decay_step,
    output logic [FRAC_BITS:0]                  sustain_level,
    output logic [FRAC_BITS:0]                  release_coef,
    output logic                                legato_on
);

    localparam int W = FRAC_BITS + 1;

    logic [W-1:0] attack_step_reg;
    logic [W-1:0] decay_step_reg;
    logic [W-1:0] sustain_level_reg;
    logic [W-1:0] release_coef_reg;
    logic         legato_on_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_step_reg   <= W'(adsr_pkg::RST_ATTACK_STEP);
            decay_step_reg    <= W'(adsr_pkg::RST_DECAY_STEP);
            sustain_level_reg <= W'(adsr_pkg::RST_SUSTAIN_LEVEL);
            release_coef_reg  <= W'(adsr_pkg::RST_RELEASE_COEF);
            legato_on_reg     <= 1'b0;
        end else if (wr_en) begin
            unique case (wr_index)
                adsr_pkg::CFG_ATTACK_STEP:   attack_step_reg   <= wr_data;
                adsr_pkg::CFG_DECAY_STEP:    decay_step_reg    <= wr_data;
                adsr_pkg::CFG_SUSTAIN_LEVEL: sustain_level_reg <= wr_data;
                adsr_pkg::CFG_RELEASE_COEF:  release_coef_reg  <= wr_data;
                adsr_pkg::CFG_LEGATO_ON:     legato_on_reg     <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign attack_step   = attack_step_reg;
    assign decay_step    = decay_step_reg;
    assign sustain_level = sustain_level_reg;
    assign release_coef  = release_coef_reg;
    assign legato_on     = legato_on_reg;

endmodule

// ===== design/adsr_env_core.sv =====
module adsr_env_core #(
    parameter int FRAC_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [1:0]           action,
    input  logic [6:0]           note,
    input  logic [FRAC_BITS:0]   attack_step,
    input  logic [FRAC_BITS:0]   decay_step,
    input  logic [FRAC_BITS:0]   sustain_level,
    input  logic [FRAC_BITS:0]   release_coef,
    input  logic                 legato_on,
    output logic [FRAC_BITS:0]   level_next,
    output adsr_pkg::stage_t     stage_next,
    output logic                 active_next
);

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE       = W'(1) << FRAC_BITS;
    localparam logic [W:0]   ONE_X     = (W+1)'(1) << FRAC_BITS;
    localparam logic [W-1:0] REL_FLOOR = W'((64'd1 << FRAC_BITS) / 1000);

    function automatic logic [W-1:0] sat_one(input logic [W-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

    logic [W-1:0]      level_reg;
    adsr_pkg::stage_t  stage_reg;
    logic              active_reg;
    logic [6:0]        note_reg;
    logic [6:0]        note_next;

    logic [W-1:0]      atk_st;
    logic [W-1:0]      dec_st;
    logic [W-1:0]      sus;
    logic [W-1:0]      rel_coef;
    logic [W:0]        atk_sum;
    logic [W-1:0]      dec_lvl;
    logic [2*W-1:0]    rel_prod;
    logic [W-1:0]      rel_dec;
    logic [W-1:0]      rel_lvl;
    logic [W-1:0]      adv_level;
    adsr_pkg::stage_t  adv_stage;

    assign sus      = sat_one(sustain_level);
    assign rel_coef = sat_one(release_coef);
    assign dec_st   = sat_one(decay_step);
    assign atk_st   = (attack_step == '0) ? W'(1) : sat_one(attack_step);
    assign atk_sum  = {1'b0, level_reg} + {1'b0, atk_st};
    assign dec_lvl  = (level_reg > dec_st) ? level_reg - dec_st : '0;
    assign rel_prod = {{W{1'b0}}, level_reg} * {{W{1'b0}}, rel_coef};
    assign rel_dec  = rel_prod[FRAC_BITS +: W];
    assign rel_lvl  = (level_reg > rel_dec) ? level_reg - rel_dec : '0;

    always_comb begin
        adv_level = '0;
        adv_stage = stage_reg;
        unique case (stage_reg)
            adsr_pkg::ST_ATTACK: begin
                if (atk_sum >= ONE_X) begin
                    adv_level = ONE;
                    adv_stage = adsr_pkg::ST_DECAY;
                end else begin
                    adv_level = atk_sum[W-1:0];
                end
            end
            adsr_pkg::ST_DECAY: begin
                if (dec_lvl <= sus) begin
                    adv_level = sus;
                    adv_stage = adsr_pkg::ST_SUSTAIN;
                end else begin
                    adv_level = dec_lvl;
                end
            end
            adsr_pkg::ST_SUSTAIN: begin
                adv_level = sus;
            end
            adsr_pkg::ST_RELEASE: begin
                if (rel_lvl <= REL_FLOOR) begin
                    adv_level = '0;
                    adv_stage = adsr_pkg::ST_OFF;
                end else begin
                    adv_level = rel_lvl;
                end
            end
            default: begin
                adv_level = '0;
            end
        endcase
    end

    always_comb begin
        level_next  = level_reg;
        stage_next  = stage_reg;
        active_next = active_reg;
        note_next   = note_reg;
        unique case (action)
            adsr_pkg::ACT_TICK: begin
                if (active_reg || stage_reg == adsr_pkg::ST_RELEASE) begin
                    level_next = adv_level;
                    stage_next = adv_stage;
                    if (adv_stage == adsr_pkg::ST_OFF) begin
                        active_next = 1'b0;
                    end
                end
            end
            adsr_pkg::ACT_NOTE_ON: begin
                note_next = note;
                if (!legato_on || !active_reg) begin
                    stage_next = adsr_pkg::ST_ATTACK;
                    level_next = '0;
                end
                active_next = 1'b1;
            end
            adsr_pkg::ACT_NOTE_OFF: begin
                if (note == note_reg) begin
                    stage_next = adsr_pkg::ST_RELEASE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= '0;
            stage_reg  <= adsr_pkg::ST_OFF;
            active_reg <= 1'b0;
            note_reg   <= '0;
        end else if (step) begin
            level_reg  <= level_next;
            stage_reg  <= stage_next;
            active_reg <= active_next;
            note_reg   <= note_next;
        end
    end

`ifndef SYNTHESIS
    a_level_max: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= ONE)
        else $error("envelope level above unity");

    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_reg == adsr_pkg::ST_OFF |-> level_reg == '0)
        else $error("off stage with nonzero level");

    a_release_end: assert property (@(posedge aclk) disable iff (!aresetn)
        step && action == adsr_pkg::ACT_TICK && stage_reg == adsr_pkg::ST_RELEASE
        && stage_next == adsr_pkg::ST_OFF |=> !active_reg)
        else $error("voice still active after release ended");

    a_retrigger: assert property (@(posedge aclk) disable iff (!aresetn)
        step && action == adsr_pkg::ACT_NOTE_ON && !legato_on
        |=> stage_reg == adsr_pkg::ST_ATTACK && level_reg == '0 && active_reg)
        else $error("note-on did not restart attack");
`endif

endmodule

// ===== design/adsr_envelope_with_gate.sv =====
// Channel | Dir | Ports                                  | Contents
// cfg     | in  | cfg_valid cfg_ready cfg_index cfg_data | register index, write value
// s       | in  | s_tvalid s_tready s_tdata s_tuser      | note, action
// m       | out | m_tvalid m_tready m_tdata              | env_level, env_stage, voice_active
//
// One item per clock while m_tready is high; an item passes the input register,
// the envelope update (one 25x25 multiply for release) and the result register
// before m_tvalid; the update also feeds back into the state registers.
// aresetn is synchronous: state goes to level zero, stage off, voice inactive.
// A stalled m side holds the result; one more item waits in the input register.
module adsr_envelope_with_gate #(
    parameter int FRAC_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [FRAC_BITS:0]                cfg_data,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // note[6:0], zero pad
    input  logic [1:0]                        s_tuser,   // action[1:0]

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // env_level[FRAC_BITS:0], env_stage[2:0], voice_active, zero pad
    output logic [((FRAC_BITS+5+7)/8)*8-1:0]  m_tdata
);

    localparam int W  = FRAC_BITS + 1;
    localparam int MW = ((FRAC_BITS + 5 + 7) / 8) * 8;

    logic [W-1:0]     attack_step;
    logic [W-1:0]     decay_step;
    logic [W-1:0]     sustain_level;
    logic [W-1:0]     release_coef;
    logic             legato_on;

    logic             in_valid_reg;
    logic [1:0]       in_action_reg;
    logic [6:0]       in_note_reg;
    logic             m_valid_reg;
    logic [MW-1:0]    m_data_reg;
    logic             advance;
    logic             s_take;

    logic [W-1:0]     level_next;
    adsr_pkg::stage_t stage_next;
    logic             active_next;

    assign cfg_ready = 1'b1;

    adsr_cfg_regs #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_en        (cfg_valid),
        .wr_index     (cfg_index),
        .wr_data      (cfg_data),
        .attack_step  (attack_step),
        .decay_step   (decay_step),
        .sustain_level(sustain_level),
        .release_coef (release_coef),
        .legato_on    (legato_on)
    );

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_action_reg <= s_tuser;
            in_note_reg   <= s_tdata[6:0];
        end
    end

    adsr_env_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .action       (in_action_reg),
        .note         (in_note_reg),
        .attack_step  (attack_step),
        .decay_step   (decay_step),
        .sustain_level(sustain_level),
        .release_coef (release_coef),
        .legato_on    (legato_on),
        .level_next   (level_next),
        .stage_next   (stage_next),
        .active_next  (active_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= MW'({active_next, adsr_pkg::stage_code(stage_next), level_next});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
